[design/mobt_pkg.sv]
package mobt_pkg;

    localparam int NUM_INPUTS   = 4;
    localparam int NUM_HIDDEN   = 4;
    localparam int FRAC_BITS    = 12;
    localparam int SIG_ENTRIES  = 256;
    localparam int SIG_W        = FRAC_BITS + 1;
    localparam int IDX_W        = $clog2(SIG_ENTRIES);
    localparam int LR_W         = 15;
    localparam int WIDX_W       = 5;

    localparam longint unsigned GRID_STEPS = 64'd65536;
    localparam longint unsigned SIG_START  = 64'd360079;
    localparam longint unsigned Q30_ONE    = 64'd1 << 30;

    localparam logic [LR_W-1:0] LR_IH_RESET = 15'd2867;
    localparam logic [LR_W-1:0] LR_HO_RESET = 15'd287;

    typedef enum logic [1:0] {
        CMD_INFER = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        REG_LR_IH = 1'b0,
        REG_LR_HO = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HSUM,
        ST_SIG,
        ST_PROD,
        ST_MERGE,
        ST_TSTEP,
        ST_UPO,
        ST_G1,
        ST_G2,
        ST_GSTEP,
        ST_UPH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic hsum;
        logic sig;
        logic prod;
        logic upo;
        logic g1;
        logic g2;
        logic gstep;
        logic uph;
        logic load;
    } lane_ctrl_t;

    typedef logic [SIG_ENTRIES-1:0][SIG_W-1:0] sig_rom_t;

    // Euler integration of s' = s(1-s) on a Q2.30 accumulator
    function automatic sig_rom_t build_sig_rom();
        sig_rom_t        rom;
        longint unsigned s;
        longint unsigned pos;
        longint unsigned tgt;
        rom = '0;
        s   = SIG_START;
        pos = 0;
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            tgt = (longint'(k) * GRID_STEPS) / SIG_ENTRIES;
            while (pos < tgt) begin
                s   = s + ((s * (Q30_ONE - s)) >> 42);
                pos = pos + 1;
            end
            rom[k] = SIG_W'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) begin
            return 16'sh7fff;
        end else if (v < -48'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

[design/mobt_lane.sv]
module mobt_lane #(
    parameter int LANE = 0
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  mobt_pkg::lane_ctrl_t                           ctrl,
    input  logic [mobt_pkg::NUM_INPUTS-1:0][15:0]          x,
    input  logic signed [15:0]                             err,
    input  logic signed [18:0]                             t,
    input  logic [mobt_pkg::LR_W-1:0]                      lr_ih,
    input  logic [mobt_pkg::WIDX_W-1:0]                    ld_idx,
    input  logic signed [15:0]                             ld_val,
    output logic signed [31:0]                             prod
);

    localparam int F = mobt_pkg::FRAC_BITS;
    localparam int NI = mobt_pkg::NUM_INPUTS;
    localparam int NH = mobt_pkg::NUM_HIDDEN;

    logic signed [15:0] w_reg [NI];
    logic signed [15:0] who_reg;
    logic [mobt_pkg::IDX_W-1:0] idx_reg;
    logic [mobt_pkg::SIG_W-1:0] h_reg;
    logic signed [31:0] prod_reg;
    logic [10:0] d_reg;
    logic [13:0] g1_reg;
    logic signed [18:0] g2_reg;
    logic signed [22:0] g_reg;

    logic signed [33:0] acc;
    logic signed [33:0] acc_sh;
    logic signed [15:0] hclamp;
    logic [15:0] u;
    logic signed [32:0] th;
    logic [25:0] dd;
    logic [25:0] g1p;
    logic signed [30:0] g2p;
    logic signed [34:0] gp;
    logic signed [15:0] who_new;
    logic signed [15:0] w_new [NI];

    // hidden sum and sigmoid index
    always_comb begin
        acc = '0;
        for (int j = 0; j < NI; j++) begin
            acc = acc + 34'(w_reg[j] * $signed(x[j]));
        end
        acc_sh = acc >>> F;
        hclamp = mobt_pkg::sat16(48'(acc_sh));
        u      = hclamp ^ 16'h8000;
    end

    // backward pass arithmetic
    always_comb begin
        th      = t * $signed({1'b0, h_reg});
        who_new = mobt_pkg::sat16(48'(who_reg) - 48'(th >>> F));
        dd      = 26'(h_reg) * 26'((mobt_pkg::SIG_W)'(1 << F) - h_reg);
        g1p     = 26'(lr_ih) * 26'(d_reg);
        g2p     = $signed({1'b0, g1_reg}) * who_reg;
        gp      = g2_reg * err;
        for (int j = 0; j < NI; j++) begin
            w_new[j] = mobt_pkg::sat16(48'(w_reg[j])
                - 48'((g_reg * $signed(x[j])) >>> F));
        end
    end

    // weights: load, update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NI; j++) begin
                w_reg[j] <= '0;
            end
            who_reg <= '0;
        end else begin
            if (ctrl.load) begin
                for (int j = 0; j < NI; j++) begin
                    if (ld_idx == mobt_pkg::WIDX_W'(j * NH + LANE)) begin
                        w_reg[j] <= ld_val;
                    end
                end
                if (ld_idx == mobt_pkg::WIDX_W'(NI * NH + LANE)) begin
                    who_reg <= ld_val;
                end
            end
            if (ctrl.upo) begin
                who_reg <= who_new;
            end
            if (ctrl.uph) begin
                for (int j = 0; j < NI; j++) begin
                    w_reg[j] <= w_new[j];
                end
            end
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (ctrl.hsum)  idx_reg  <= u[15 -: mobt_pkg::IDX_W];
        if (ctrl.sig)   h_reg    <= mobt_pkg::SIG_ROM[idx_reg];
        if (ctrl.prod)  prod_reg <= who_reg * $signed({3'b0, h_reg});
        if (ctrl.upo)   d_reg    <= 11'(dd >> F);
        if (ctrl.g1)    g1_reg   <= 14'(g1p >> F);
        if (ctrl.g2)    g2_reg   <= 19'(g2p >>> F);
        if (ctrl.gstep) g_reg    <= 23'(gp >>> F);
    end

    assign prod = prod_reg;

endmodule

[design/mobt_merge.sv]
module mobt_merge (
    input  logic                                       aclk,
    input  logic                                       merge_en,
    input  logic                                       t_en,
    input  logic [mobt_pkg::NUM_HIDDEN-1:0][31:0]      prods,
    input  logic signed [15:0]                         target_value,
    input  logic [mobt_pkg::LR_W-1:0]                  lr_ho,
    output logic signed [15:0]                         pred,
    output logic signed [15:0]                         err,
    output logic signed [18:0]                         t
);

    localparam int F = mobt_pkg::FRAC_BITS;

    logic signed [15:0] pred_reg;
    logic signed [15:0] err_reg;
    logic signed [18:0] t_reg;
    logic signed [33:0] sum;
    logic signed [15:0] pred_c;
    logic signed [15:0] err_c;
    logic signed [31:0] tp;

    // combine lane products into the output unit
    always_comb begin
        sum = '0;
        for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++) begin
            sum = sum + 34'($signed(prods[i]));
        end
        pred_c = mobt_pkg::sat16(48'(sum >>> F));
        err_c  = mobt_pkg::sat16(48'(pred_c) - 48'(target_value));
        tp     = $signed({17'b0, lr_ho}) * 32'(err_reg);
    end

    always_ff @(posedge aclk) begin
        if (merge_en) begin
            pred_reg <= pred_c;
            err_reg  <= err_c;
        end
        if (t_en) t_reg <= 19'(tp >>> F);
    end

    assign pred = pred_reg;
    assign err  = err_reg;
    assign t    = t_reg;

endmodule

[design/mlp_online_backprop_trainer_core.sv]
// Infer runs HSUM, SIG, PROD, MERGE, DONE; train adds TSTEP, UPO, G1,
// G2, GSTEP, UPH after MERGE; load runs LOAD, DONE. One item at a time;
// the dependent forward and backward steps use one lane per hidden unit.
// Reset (aresetn low, synchronous): weights clear to zero, learning rates
// return to 0.7 and 0.07, sequencer goes idle, no result is pending.
module mlp_online_backprop_trainer_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [15:0] s_feature_0,
    input  logic signed [15:0] s_feature_1,
    input  logic signed [15:0] s_feature_2,
    input  logic signed [15:0] s_feature_3,
    input  logic signed [15:0] s_target_value,
    input  logic [4:0]         s_weight_index,
    input  logic signed [15:0] s_weight_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_prediction,
    output logic signed [15:0] m_output_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NH = mobt_pkg::NUM_HIDDEN;

    mobt_pkg::state_t state_reg, state_next;
    mobt_pkg::lane_ctrl_t ctrl;
    logic merge_en, t_en, out_load;

    logic [mobt_pkg::LR_W-1:0] lr_ih_reg, lr_ho_reg;
    logic [1:0] cmd_reg;
    logic [mobt_pkg::NUM_INPUTS-1:0][15:0] x_reg;
    logic signed [15:0] target_reg;
    logic [4:0] widx_reg;
    logic signed [15:0] wval_reg;
    logic m_valid_reg;
    logic signed [15:0] pred_out_reg, err_out_reg;

    logic [NH-1:0][31:0] prods;
    logic signed [15:0] pred, err;
    logic signed [18:0] t;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == mobt_pkg::ST_IDLE);
    assign pready   = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_ih_reg <= mobt_pkg::LR_IH_RESET;
            lr_ho_reg <= mobt_pkg::LR_HO_RESET;
        end else if (psel && penable && pwrite) begin
            case (mobt_pkg::reg_idx_t'(paddr[2]))
                mobt_pkg::REG_LR_IH: lr_ih_reg <= pwdata[mobt_pkg::LR_W-1:0];
                mobt_pkg::REG_LR_HO: lr_ho_reg <= pwdata[mobt_pkg::LR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (mobt_pkg::reg_idx_t'(paddr[2]))
            mobt_pkg::REG_LR_IH: prdata = {17'b0, lr_ih_reg};
            mobt_pkg::REG_LR_HO: prdata = {17'b0, lr_ho_reg};
            default:             prdata = '0;
        endcase
    end

    // capture the input beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_cmd;
            x_reg      <= {s_feature_3, s_feature_2, s_feature_1, s_feature_0};
            target_reg <= s_target_value;
            widx_reg   <= s_weight_index;
            wval_reg   <= s_weight_value;
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= mobt_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mobt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (mobt_pkg::cmd_t'(s_cmd) == mobt_pkg::CMD_LOAD)
                        state_next = mobt_pkg::ST_LOAD;
                    else
                        state_next = mobt_pkg::ST_HSUM;
                end
            end
            mobt_pkg::ST_LOAD:  state_next = mobt_pkg::ST_DONE;
            mobt_pkg::ST_HSUM:  state_next = mobt_pkg::ST_SIG;
            mobt_pkg::ST_SIG:   state_next = mobt_pkg::ST_PROD;
            mobt_pkg::ST_PROD:  state_next = mobt_pkg::ST_MERGE;
            mobt_pkg::ST_MERGE: begin
                if (mobt_pkg::cmd_t'(cmd_reg) == mobt_pkg::CMD_TRAIN)
                    state_next = mobt_pkg::ST_TSTEP;
                else
                    state_next = mobt_pkg::ST_DONE;
            end
            mobt_pkg::ST_TSTEP: state_next = mobt_pkg::ST_UPO;
            mobt_pkg::ST_UPO:   state_next = mobt_pkg::ST_G1;
            mobt_pkg::ST_G1:    state_next = mobt_pkg::ST_G2;
            mobt_pkg::ST_G2:    state_next = mobt_pkg::ST_GSTEP;
            mobt_pkg::ST_GSTEP: state_next = mobt_pkg::ST_UPH;
            mobt_pkg::ST_UPH:   state_next = mobt_pkg::ST_DONE;
            mobt_pkg::ST_DONE:  if (out_free) state_next = mobt_pkg::ST_IDLE;
            default:            state_next = mobt_pkg::ST_IDLE;
        endcase
    end

    // strobes per state
    always_comb begin
        ctrl     = '0;
        merge_en = 1'b0;
        t_en     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            mobt_pkg::ST_LOAD:  ctrl.load  = 1'b1;
            mobt_pkg::ST_HSUM:  ctrl.hsum  = 1'b1;
            mobt_pkg::ST_SIG:   ctrl.sig   = 1'b1;
            mobt_pkg::ST_PROD:  ctrl.prod  = 1'b1;
            mobt_pkg::ST_MERGE: merge_en   = 1'b1;
            mobt_pkg::ST_TSTEP: t_en       = 1'b1;
            mobt_pkg::ST_UPO:   ctrl.upo   = 1'b1;
            mobt_pkg::ST_G1:    ctrl.g1    = 1'b1;
            mobt_pkg::ST_G2:    ctrl.g2    = 1'b1;
            mobt_pkg::ST_GSTEP: ctrl.gstep = 1'b1;
            mobt_pkg::ST_UPH:   ctrl.uph   = 1'b1;
            mobt_pkg::ST_DONE:  out_load   = out_free;
            default: ;
        endcase
    end

    // one lane per hidden unit
    for (genvar i = 0; i < NH; i++) begin : g_lane
        mobt_lane #(.LANE(i)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .x       (x_reg),
            .err     (err),
            .t       (t),
            .lr_ih   (lr_ih_reg),
            .ld_idx  (widx_reg),
            .ld_val  (wval_reg),
            .prod    (prods[i])
        );
    end

    mobt_merge u_merge (
        .aclk         (aclk),
        .merge_en     (merge_en),
        .t_en         (t_en),
        .prods        (prods),
        .target_value (target_reg),
        .lr_ho        (lr_ho_reg),
        .pred         (pred),
        .err          (err),
        .t            (t)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (mobt_pkg::cmd_t'(cmd_reg) == mobt_pkg::CMD_LOAD) begin
                pred_out_reg <= '0;
                err_out_reg  <= '0;
            end else begin
                pred_out_reg <= pred;
                err_out_reg  <= err;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_prediction   = pred_out_reg;
    assign m_output_error = err_out_reg;

    a_load_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (mobt_pkg::cmd_t'(s_cmd) == mobt_pkg::CMD_LOAD)
        |=> state_reg == mobt_pkg::ST_LOAD)
        else $error("load beat did not enter load state");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while busy");

    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (mobt_pkg::cmd_t'(cmd_reg) == mobt_pkg::CMD_LOAD)
        |=> m_valid && m_prediction == 16'sd0 && m_output_error == 16'sd0)
        else $error("load result not zero");

endmodule

[sim/mlp_online_backprop_trainer_core_test.sv]
module mlp_online_backprop_trainer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W = mobt_pkg::NUM_INPUTS * mobt_pkg::NUM_HIDDEN;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = mobt_pkg::CMD_INFER;
    logic signed [15:0] s_feature_0 = '0;
    logic signed [15:0] s_feature_1 = '0;
    logic signed [15:0] s_feature_2 = '0;
    logic signed [15:0] s_feature_3 = '0;
    logic signed [15:0] s_target_value = '0;
    logic [4:0]         s_weight_index = '0;
    logic signed [15:0] s_weight_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_prediction;
    logic signed [15:0] m_output_error;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mlp_online_backprop_trainer_core u_top (.*);

    always #1 aclk = ~aclk;

    // network state mirrored by the predictor
    longint ih_w[NUM_W];
    longint ho_w[mobt_pkg::NUM_HIDDEN];
    longint lr_ih;
    longint lr_ho;
    longint sig_lut[mobt_pkg::SIG_ENTRIES];

    typedef struct {
        logic signed [15:0] pred;
        logic signed [15:0] err;
    } net_out_t;

    net_out_t pending_outs[$];
    int       mismatches;
    int       n_train;
    int       n_infer;
    int       n_load;
    int       n_outs;
    bit       burst_on;

    function automatic longint shr(longint v);
        return v >>> mobt_pkg::FRAC_BITS;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void build_lut();
        longint unsigned s;
        longint unsigned pos;
        longint unsigned tgt;
        s = 64'd360079;
        pos = 0;
        for (int k = 0; k < mobt_pkg::SIG_ENTRIES; k++) begin
            tgt = (longint'(k) * 65536) / mobt_pkg::SIG_ENTRIES;
            while (pos < tgt) begin
                s = s + ((s * ((64'd1 << 30) - s)) >> 42);
                pos++;
            end
            sig_lut[k] = longint'((s + (64'd1 << (29 - mobt_pkg::FRAC_BITS)))
                                  >> (30 - mobt_pkg::FRAC_BITS));
        end
    endfunction

    function automatic longint sigmoid_of(longint x);
        longint lim;
        longint idx;
        lim = longint'(8) << mobt_pkg::FRAC_BITS;
        if (x < -lim) x = -lim;
        if (x > lim - 1) x = lim - 1;
        idx = ((x + lim) * mobt_pkg::SIG_ENTRIES) / (longint'(16) << mobt_pkg::FRAC_BITS);
        if (idx >= mobt_pkg::SIG_ENTRIES) idx = mobt_pkg::SIG_ENTRIES - 1;
        return sig_lut[idx];
    endfunction

    // forward pass, optional SGD step, or weight load
    function automatic net_out_t run_net(logic [1:0] cmd, logic signed [15:0] f0,
                                         logic signed [15:0] f1, logic signed [15:0] f2,
                                         logic signed [15:0] f3, logic signed [15:0] tgt,
                                         logic [4:0] widx, logic signed [15:0] wval);
        net_out_t r;
        longint   x[mobt_pkg::NUM_INPUTS];
        longint   h[mobt_pkg::NUM_HIDDEN];
        longint   acc;
        longint   pred;
        longint   err;
        longint   t;
        longint   d;
        longint   g;
        r.pred = '0;
        r.err = '0;
        if (cmd == mobt_pkg::CMD_LOAD) begin
            if (widx < NUM_W) ih_w[widx] = wval;
            else if (widx < NUM_W + mobt_pkg::NUM_HIDDEN) ho_w[widx - NUM_W] = wval;
            return r;
        end
        x[0] = f0; x[1] = f1; x[2] = f2; x[3] = f3;
        for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++) begin
            acc = 0;
            for (int j = 0; j < mobt_pkg::NUM_INPUTS; j++)
                acc += ih_w[j * mobt_pkg::NUM_HIDDEN + i] * x[j];
            h[i] = sigmoid_of(shr(acc));
        end
        acc = 0;
        for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++) acc += ho_w[i] * h[i];
        pred = clip16(shr(acc));
        err = clip16(pred - longint'(tgt));
        if (cmd == mobt_pkg::CMD_TRAIN) begin
            t = shr(lr_ho * err);
            for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++)
                ho_w[i] = clip16(ho_w[i] - shr(t * h[i]));
            for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++) begin
                d = shr(h[i] * ((longint'(1) << mobt_pkg::FRAC_BITS) - h[i]));
                g = shr(lr_ih * d);
                g = shr(g * ho_w[i]);
                g = shr(g * err);
                for (int j = 0; j < mobt_pkg::NUM_INPUTS; j++)
                    ih_w[j * mobt_pkg::NUM_HIDDEN + i] =
                        clip16(ih_w[j * mobt_pkg::NUM_HIDDEN + i] - shr(g * x[j]));
            end
        end
        r.pred = pred[15:0];
        r.err = err[15:0];
        return r;
    endfunction

    // send one beat, with random gaps between bursts
    task automatic send_beat(logic [1:0] cmd, logic signed [15:0] f0, logic signed [15:0] f1,
                             logic signed [15:0] f2, logic signed [15:0] f3,
                             logic signed [15:0] tgt, logic [4:0] widx,
                             logic signed [15:0] wval);
        if (!burst_on) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_on = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) burst_on = 1'b0;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_feature_0 <= f0;
        s_feature_1 <= f1;
        s_feature_2 <= f2;
        s_feature_3 <= f3;
        s_target_value <= tgt;
        s_weight_index <= widx;
        s_weight_value <= wval;
        do @(posedge aclk); while (!s_ready);
        pending_outs.push_back(run_net(cmd, f0, f1, f2, f3, tgt, widx, wval));
        case (cmd)
            mobt_pkg::CMD_LOAD:  n_load++;
            mobt_pkg::CMD_TRAIN: n_train++;
            default:             n_infer++;
        endcase
    endtask

    task automatic send_load(logic [4:0] widx, logic signed [15:0] wval);
        send_beat(mobt_pkg::CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), widx, wval);
    endtask

    task automatic send_sample(logic [1:0] cmd, logic [15:0] amp);
        send_beat(cmd, 16'($urandom) & amp, 16'($urandom) & amp, 16'($urandom) & amp,
                  16'($urandom) & amp, 16'($urandom) & amp, 5'($urandom), 16'($urandom));
    endtask

    // wait for every result, then let the load path settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(mobt_pkg::reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == mobt_pkg::REG_LR_IH) lr_ih = value & 32'h7fff;
        else lr_ho = value & 32'h7fff;
        @(posedge aclk);
    endtask

    task automatic load_random_net(int amp);
        for (int i = 0; i < NUM_W + mobt_pkg::NUM_HIDDEN; i++)
            send_load(5'(i), 16'($urandom_range(0, 2 * amp) - amp));
    endtask

    // extremes, every command, dropped loads, spare command
    task automatic test_directed();
        send_sample(mobt_pkg::CMD_INFER, 16'hffff);
        send_load(5'd0, 16'sh7fff);
        send_load(5'(NUM_W), 16'sh8000);
        send_load(5'(NUM_W + mobt_pkg::NUM_HIDDEN), 16'sh1234);
        send_load(5'd31, 16'sh7fff);
        send_beat(mobt_pkg::CMD_INFER, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                  5'd0, 16'sh0000);
        send_beat(mobt_pkg::CMD_TRAIN, 16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh7fff,
                  5'd0, 16'sh0000);
        send_beat(mobt_pkg::CMD_SPARE, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh8000,
                  5'd0, 16'sh0000);
        for (int i = NUM_W; i < NUM_W + mobt_pkg::NUM_HIDDEN; i++)
            send_load(5'(i), 16'sh7fff);
        send_beat(mobt_pkg::CMD_INFER, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  5'd0, 16'sh0000);
        send_beat(mobt_pkg::CMD_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                  5'd0, 16'sh0000);
        load_random_net(4096);
        send_beat(mobt_pkg::CMD_TRAIN, 16'sh1000, 16'shf000, 16'sh0800, 16'sh0000, 16'sh0000,
                  5'd0, 16'sh0000);
        drain();
    endtask

    // training runs from freshly loaded nets under a given pair of rates
    task automatic test_training(logic [31:0] ih, logic [31:0] ho, int n);
        write_reg(mobt_pkg::REG_LR_IH, ih);
        write_reg(mobt_pkg::REG_LR_HO, ho);
        load_random_net($urandom_range(0, 1) ? 8192 : 32767);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       send_sample(mobt_pkg::CMD_INFER, 16'hffff);
                1:       send_sample(mobt_pkg::CMD_SPARE, 16'h3fff);
                2:       send_load(5'($urandom_range(0, 31)), 16'($urandom));
                3:       send_sample(mobt_pkg::CMD_TRAIN, 16'hffff);
                default: send_sample(mobt_pkg::CMD_TRAIN, 16'h1fff);
            endcase
        end
        drain();
    endtask

    // result check against the oldest expectation
    always @(posedge aclk) begin
        net_out_t e;
        if (aresetn && m_valid && m_ready) begin
            n_outs++;
            if (pending_outs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %0d", n_outs);
            end else begin
                e = pending_outs.pop_front();
                if (m_prediction !== e.pred || m_output_error !== e.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected pred %0d err %0d, got pred %0d err %0d",
                                 n_outs, e.pred, e.err, m_prediction, m_output_error);
                end
            end
        end
    end

    // receiver stall pattern: phases of free flow and random backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (n_outs % 200 < 60) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_W; i++) ih_w[i] = 0;
        for (int i = 0; i < mobt_pkg::NUM_HIDDEN; i++) ho_w[i] = 0;
        lr_ih = mobt_pkg::LR_IH_RESET;
        lr_ho = mobt_pkg::LR_HO_RESET;
        build_lut();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_training(32'h7fff, 32'h7fff, 150);
        test_training(32'h0, 32'h0, 150);
        test_training(32'hffff_ffff, 32'h1, 100);
        test_training(32'(mobt_pkg::LR_IH_RESET), 32'(mobt_pkg::LR_HO_RESET), 200);
        test_training($urandom, $urandom, 250);
        test_training($urandom_range(0, 4096), $urandom_range(0, 4096), 250);
        $display("covered %0d train, %0d infer, %0d load beats; %0d results, learning rates swept",
                 n_train, n_infer, n_load, n_outs);
        if (mismatches == 0 && pending_outs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("mismatches %0d, outstanding %0d", mismatches, pending_outs.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

[mlp_online_backprop_trainer_core.f]
design/mobt_pkg.sv
design/mobt_lane.sv
design/mobt_merge.sv
design/mlp_online_backprop_trainer_core.sv
sim/mlp_online_backprop_trainer_core_test.sv
